### hdl/ipv4_rx_header_filter_top_defines.svh
// Assertion macros shared by the IPv4 receive header filter RTL.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef IPV4_RX_HEADER_FILTER_TOP_DEFINES_SVH
`define IPV4_RX_HEADER_FILTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define IHF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ihf: implication check failed");

// Next-cycle implication.
`define IHF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ihf: next-cycle check failed");

`endif

### hdl/ihf_pkg.sv
// Package for the IPv4 receive header filter: verdict codes, header constants,
// capture struct. No dependencies.
package ihf_pkg;

  typedef enum logic [3:0] {
    VERDICT_ICMP          = 4'd0,
    VERDICT_UDP           = 4'd1,
    VERDICT_SHORT         = 4'd2,
    VERDICT_NOT_V4        = 4'd3,
    VERDICT_BAD_LEN       = 4'd4,
    VERDICT_BAD_CSUM      = 4'd5,
    VERDICT_NOT_OURS      = 4'd6,
    VERDICT_FRAGMENT      = 4'd7,
    VERDICT_UNKNOWN_PROTO = 4'd8
  } verdict_e;

  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
  localparam logic [15:0] CNT_MAX       = 16'hFFFF;
  localparam logic [7:0]  VERSION_MASK  = 8'hF0;
  localparam logic [7:0]  VERSION_V4    = 8'h40;
  localparam logic [15:0] FRAG_MASK     = 16'h3FFF; // MF flag and offset
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;
  localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;

  // Header byte positions
  localparam logic [15:0] POS_VER_IHL  = 16'd0;
  localparam logic [15:0] POS_TLEN_HI  = 16'd2;
  localparam logic [15:0] POS_TLEN_LO  = 16'd3;
  localparam logic [15:0] POS_FRAG_HI  = 16'd6;
  localparam logic [15:0] POS_FRAG_LO  = 16'd7;
  localparam logic [15:0] POS_PROTO    = 16'd9;
  localparam logic [15:0] POS_SRC_LO   = 16'd12;
  localparam logic [15:0] POS_DST_LO   = 16'd16;
  localparam logic [15:0] POS_DST_END  = 16'd20;

  // APB register map
  localparam int unsigned APB_AW        = 3;
  localparam logic        REG_LOCAL_ADDR = 1'b0;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  ver_ihl;
    logic [15:0] total_len;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [20:0] csum;
  } cap_t;

endpackage

### hdl/ihf_apb_regs.sv
// APB configuration register for the header filter (local address).
// Depends on ihf_pkg.
module ihf_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ihf_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [31:0]                   local_address_o
);

  logic [31:0] local_addr_q, local_addr_d;
  logic        sel_local;

  assign pready    = 1'b1;
  assign sel_local = (paddr[ihf_pkg::APB_AW-1:2] == ihf_pkg::REG_LOCAL_ADDR);

  always_comb begin
    local_addr_d = local_addr_q;
    if (psel && penable && pwrite && pready && sel_local) begin
      local_addr_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else begin
      local_addr_q <= local_addr_d;
    end
  end

  assign prdata          = sel_local ? local_addr_q : '0;
  assign local_address_o = local_addr_q;

endmodule

### hdl/ihf_frame.sv
// Input register, per-frame header capture and checksum accumulation.
// Depends on ihf_pkg and the defines header.
`include "ipv4_rx_header_filter_top_defines.svh"

module ihf_frame (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    frame_byte_i,
  input  logic          last_byte_i,
  output logic          cap_valid_o,
  input  logic          cap_ready_i,
  output ihf_pkg::cap_t cap_o
);

  logic          in_vld_q, in_vld_d;
  logic [7:0]    in_byte_q;
  logic          in_last_q;
  ihf_pkg::cap_t fr_q, fr_d, fr_nxt;
  logic [7:0]    pend_q, pend_d, pend_nxt;
  logic          cap_vld_q, cap_vld_d;
  ihf_pkg::cap_t cap_q;
  logic          cap_free, s1_adv, take;
  logic [15:0]   idx;
  logic [5:0]    hlen;

  assign cap_free   = !cap_vld_q || cap_ready_i;
  assign s1_adv     = in_vld_q && (!in_last_q || cap_free);
  assign in_ready_o = !in_vld_q || s1_adv;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (s1_adv) begin
      in_vld_d = 1'b0;
    end
  end

  // Header field capture, checksum accumulation and byte count for the byte in the input register
  always_comb begin
    idx      = fr_q.byte_count;
    fr_nxt   = fr_q;
    pend_nxt = pend_q;
    if (idx == ihf_pkg::POS_VER_IHL) begin
      fr_nxt.ver_ihl = in_byte_q;
    end else if (idx == ihf_pkg::POS_TLEN_HI) begin
      fr_nxt.total_len[15:8] = in_byte_q;
    end else if (idx == ihf_pkg::POS_TLEN_LO) begin
      fr_nxt.total_len[7:0] = in_byte_q;
    end else if (idx == ihf_pkg::POS_FRAG_HI) begin
      fr_nxt.frag[15:8] = in_byte_q;
    end else if (idx == ihf_pkg::POS_FRAG_LO) begin
      fr_nxt.frag[7:0] = in_byte_q;
    end else if (idx == ihf_pkg::POS_PROTO) begin
      fr_nxt.proto = in_byte_q;
    end else if (idx >= ihf_pkg::POS_SRC_LO && idx < ihf_pkg::POS_DST_LO) begin
      fr_nxt.src = {fr_q.src[23:0], in_byte_q};
    end else if (idx >= ihf_pkg::POS_DST_LO && idx < ihf_pkg::POS_DST_END) begin
      fr_nxt.dst = {fr_q.dst[23:0], in_byte_q};
    end
    hlen = {fr_nxt.ver_ihl[3:0], 2'b00};
    if (idx < {10'd0, hlen}) begin
      if (!idx[0]) begin
        pend_nxt = in_byte_q;
      end else begin
        fr_nxt.csum = fr_q.csum + {5'd0, pend_q, in_byte_q};
      end
    end
    if (idx != ihf_pkg::CNT_MAX) begin
      fr_nxt.byte_count = idx + 16'd1;
    end
  end

  always_comb begin
    fr_d      = fr_q;
    pend_d    = pend_q;
    cap_vld_d = cap_vld_q;
    if (s1_adv) begin
      if (in_last_q) begin
        fr_d   = '0;
        pend_d = '0;
      end else begin
        fr_d   = fr_nxt;
        pend_d = pend_nxt;
      end
    end
    if (cap_free) begin
      cap_vld_d = s1_adv && in_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      fr_q      <= '0;
      pend_q    <= '0;
      cap_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      fr_q      <= fr_d;
      pend_q    <= pend_d;
      cap_vld_q <= cap_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= frame_byte_i;
      in_last_q <= last_byte_i;
    end
    if (cap_free && s1_adv && in_last_q) begin
      cap_q <= fr_nxt;
    end
  end

  assign cap_valid_o = cap_vld_q;
  assign cap_o       = cap_q;

  `IHF_ASSERT_NXT(a_cnt_step, s1_adv && !in_last_q && (fr_q.byte_count != ihf_pkg::CNT_MAX), fr_q.byte_count == $past(fr_q.byte_count) + 16'd1)
  `IHF_ASSERT_NXT(a_frame_clear, s1_adv && in_last_q, fr_q.byte_count == 16'd0 && pend_q == 8'd0)
  `IHF_ASSERT_NXT(a_cap_hold, cap_vld_q && !cap_ready_i, cap_vld_q && $stable(cap_q))

endmodule

### hdl/ihf_verdict.sv
// Verdict evaluation and output register for one captured header.
// Depends on ihf_pkg and the defines header.
`include "ipv4_rx_header_filter_top_defines.svh"

module ihf_verdict (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cap_valid_i,
  output logic              cap_ready_o,
  input  ihf_pkg::cap_t     cap_i,
  input  logic [31:0]       local_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        verdict_o,
  output logic              learn_sender_o,
  output logic [31:0]       source_address_o,
  output logic [31:0]       dest_address_o,
  output logic [7:0]        protocol_number_o,
  output logic [5:0]        payload_offset_o,
  output logic [15:0]       payload_length_o
);

  logic              out_valid_q, out_valid_d;
  ihf_pkg::verdict_e verdict_q, verdict_d;
  logic              learn_q, learn_d;
  logic [31:0]       src_q, dst_q;
  logic [7:0]        proto_q;
  logic [5:0]        hlen_q, hlen;
  logic [15:0]       plen_q, plen_d;
  logic [15:0]       hlen16;
  logic [16:0]       fold1;
  logic [15:0]       fold2;
  logic              csum_ok, len_bad, load;

  assign cap_ready_o = !out_valid_q || out_ready_i;
  assign load        = cap_valid_i && cap_ready_o;

  always_comb begin
    hlen    = {cap_i.ver_ihl[3:0], 2'b00};
    hlen16  = {10'd0, hlen};
    fold1   = {1'b0, cap_i.csum[15:0]} + {12'd0, cap_i.csum[20:16]};
    fold2   = fold1[15:0] + {15'd0, fold1[16]};
    csum_ok = (fold2 == ihf_pkg::CSUM_GOOD);
    len_bad = (hlen16 < ihf_pkg::MIN_HDR_BYTES) || (cap_i.byte_count < hlen16) ||
              (cap_i.total_len < hlen16) || (cap_i.total_len > cap_i.byte_count);
    learn_d = 1'b0;
    if (cap_i.byte_count < ihf_pkg::MIN_HDR_BYTES) begin
      verdict_d = ihf_pkg::VERDICT_SHORT;
    end else if ((cap_i.ver_ihl & ihf_pkg::VERSION_MASK) != ihf_pkg::VERSION_V4) begin
      verdict_d = ihf_pkg::VERDICT_NOT_V4;
    end else if (len_bad) begin
      verdict_d = ihf_pkg::VERDICT_BAD_LEN;
    end else if (!csum_ok) begin
      verdict_d = ihf_pkg::VERDICT_BAD_CSUM;
    end else if (cap_i.dst != local_address_i && cap_i.dst != ihf_pkg::BCAST_ADDR) begin
      verdict_d = ihf_pkg::VERDICT_NOT_OURS;
    end else begin
      learn_d = 1'b1;
      if ((cap_i.frag & ihf_pkg::FRAG_MASK) != 16'd0) begin
        verdict_d = ihf_pkg::VERDICT_FRAGMENT;
      end else if (cap_i.proto == ihf_pkg::PROTO_ICMP) begin
        verdict_d = ihf_pkg::VERDICT_ICMP;
      end else if (cap_i.proto == ihf_pkg::PROTO_UDP) begin
        verdict_d = ihf_pkg::VERDICT_UDP;
      end else begin
        verdict_d = ihf_pkg::VERDICT_UNKNOWN_PROTO;
      end
    end
    plen_d = (cap_i.total_len >= hlen16) ? (cap_i.total_len - hlen16) : 16'd0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cap_ready_o) begin
      out_valid_d = cap_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      verdict_q <= verdict_d;
      learn_q   <= learn_d;
      src_q     <= cap_i.src;
      dst_q     <= cap_i.dst;
      proto_q   <= cap_i.proto;
      hlen_q    <= hlen;
      plen_q    <= plen_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign learn_sender_o    = learn_q;
  assign source_address_o  = src_q;
  assign dest_address_o    = dst_q;
  assign protocol_number_o = proto_q;
  assign payload_offset_o  = hlen_q;
  assign payload_length_o  = plen_q;

  `IHF_ASSERT_IMP(a_learn_codes, out_valid_q && learn_q, verdict_q == ihf_pkg::VERDICT_ICMP || verdict_q == ihf_pkg::VERDICT_UDP || verdict_q == ihf_pkg::VERDICT_FRAGMENT || verdict_q == ihf_pkg::VERDICT_UNKNOWN_PROTO)
  `IHF_ASSERT_IMP(a_pass_learns, out_valid_q && !learn_q, verdict_q != ihf_pkg::VERDICT_ICMP && verdict_q != ihf_pkg::VERDICT_UDP)

endmodule

### hdl/ipv4_rx_header_filter_top.sv
// IPv4 receive header filter, top level: one frame byte per transaction in,
// one verdict transaction per frame out. Takes a byte every clock cycle while
// ready is high; a verdict is registered after the frame's last byte is
// accepted (the byte lands in the input register on acceptance, then the
// header capture register and the verdict register follow). Ready falls only
// when a last byte is held behind a captured header that the verdict stage has
// not yet taken. Depends on ihf_pkg, ihf_apb_regs, ihf_frame, ihf_verdict.
module ipv4_rx_header_filter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ihf_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 frame_byte_i,
  input  logic                       last_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 verdict_o,
  output logic                       learn_sender_o,
  output logic [31:0]                source_address_o,
  output logic [31:0]                dest_address_o,
  output logic [7:0]                 protocol_number_o,
  output logic [5:0]                 payload_offset_o,
  output logic [15:0]                payload_length_o
);

  logic [31:0]   local_address;
  logic          cap_valid, cap_ready;
  ihf_pkg::cap_t cap;

  ihf_apb_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .local_address_o (local_address)
  );

  ihf_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_byte_i (frame_byte_i),
    .last_byte_i  (last_byte_i),
    .cap_valid_o  (cap_valid),
    .cap_ready_i  (cap_ready),
    .cap_o        (cap)
  );

  ihf_verdict u_verdict (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cap_valid_i       (cap_valid),
    .cap_ready_o       (cap_ready),
    .cap_i             (cap),
    .local_address_i   (local_address),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .verdict_o         (verdict_o),
    .learn_sender_o    (learn_sender_o),
    .source_address_o  (source_address_o),
    .dest_address_o    (dest_address_o),
    .protocol_number_o (protocol_number_o),
    .payload_offset_o  (payload_offset_o),
    .payload_length_o  (payload_length_o)
  );

endmodule
